@@ rtl/planar_tile_image_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// Planar tile image decoder assertion macros
// Shared property macros for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef PLANAR_TILE_IMAGE_DECODER_MACROS_SVH
`define PLANAR_TILE_IMAGE_DECODER_MACROS_SVH

// same-cycle implication
`define PTID_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PTID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ptid_pkg.sv @@
// ----------------------------------------------------------------------------
// ptid_pkg
// Types and constants of the planar tile image decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptid_pkg;

   localparam int ADDR_WIDTH = 5;
   localparam int DATA_WIDTH = 32;

   localparam logic [10:0] TILE_LIMIT = 11'd1024;
   localparam logic [6:0]  GRID_LIMIT = 7'd64;

   localparam logic [31:0] PALETTE_0_RESET = 32'hffffffff;
   localparam logic [31:0] PALETTE_1_RESET = 32'hffaaaaaa;
   localparam logic [31:0] PALETTE_2_RESET = 32'hff555555;
   localparam logic [31:0] PALETTE_3_RESET = 32'hff000000;
   localparam logic [6:0]  GRID_WIDTH_RESET = 7'd16;
   localparam logic [10:0] TILE_TOTAL_RESET = 11'd1024;

   typedef enum logic [2:0] {
      REG_PALETTE_0  = 3'd0,
      REG_PALETTE_1  = 3'd1,
      REG_PALETTE_2  = 3'd2,
      REG_PALETTE_3  = 3'd3,
      REG_TALL_TILES = 3'd4,
      REG_GRID_WIDTH = 3'd5,
      REG_TILE_TOTAL = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [3:0][31:0] palette;
      logic             tall_tiles;
      logic [6:0]       grid_width_tiles;
      logic [10:0]      tile_total;
   } cfg_type;

   typedef struct packed {
      logic [7:0] plane_high;
      logic [7:0] plane_low;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_0;
      logic [31:0] pixel_1;
      logic [31:0] pixel_2;
      logic [31:0] pixel_3;
      logic [31:0] pixel_4;
      logic [31:0] pixel_5;
      logic [31:0] pixel_6;
      logic [31:0] pixel_7;
      logic [13:0] dest_row;
      logic [8:0]  dest_column;
      logic        image_done;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/planar_tile_image_decoder.sv @@
// ----------------------------------------------------------------------------
// planar_tile_image_decoder
// 2bpp planar tile line decoder with palette lookup and grid placement.
//
//   channel   direction  handshake                 payload
//   req       in         req_valid / req_stall     ptid_pkg::req_type
//   rsp       out        rsp_valid / rsp_stall     ptid_pkg::rsp_type
//   csr       in/out     psel/penable/pready       APB, 32-bit data
//
// One line per cycle while the output is not stalled; each result is registered in rsp_data_ff.
// A one-entry skid register holds a line while the result register is
// stalled, so req_stall is registered and never depends on rsp_stall.
// Synchronous reset clears counters and valids and sets CSRs to defaults; data registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module planar_tile_image_decoder (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [ptid_pkg::ADDR_WIDTH-1:0]  paddr,
   input  wire logic [ptid_pkg::DATA_WIDTH-1:0]  pwdata,
   output logic      [ptid_pkg::DATA_WIDTH-1:0]  prdata,
   output logic                                  pready,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire ptid_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output ptid_pkg::rsp_type                     rsp_data
);

   ptid_pkg::cfg_type cfg;
   ptid_pkg::req_type skid_data_ff, skid_data_in;
   ptid_pkg::req_type line_data;
   ptid_pkg::rsp_type line_result;
   ptid_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              skid_valid_ff, skid_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_ready;
   logic              req_accept;
   logic              line_advance;

   ptid_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign out_ready    = !rsp_valid_ff || !rsp_stall;
   assign req_accept   = req_valid && !skid_valid_ff;
   assign line_data    = skid_valid_ff ? skid_data_ff : req_data;
   assign line_advance = out_ready && (skid_valid_ff || req_accept);

   ptid_line u_line (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .advance   (line_advance),
      .line_data (line_data),
      .result    (line_result)
   );

   always_comb begin
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = line_advance ? line_result : rsp_data_ff;
      if (out_ready) begin
         rsp_valid_in  = skid_valid_ff || req_accept;
         skid_valid_in = 1'b0;
      end else if (req_accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      skid_data_ff <= skid_data_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ rtl/ptid_csr.sv @@
// ----------------------------------------------------------------------------
// ptid_csr
// APB register file: palette colors and tile grid geometry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptid_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [ptid_pkg::ADDR_WIDTH-1:0]  paddr,
   input  wire logic [ptid_pkg::DATA_WIDTH-1:0]  pwdata,
   output logic      [ptid_pkg::DATA_WIDTH-1:0]  prdata,
   output logic                                  pready,
   output ptid_pkg::cfg_type                     cfg
);

   ptid_pkg::cfg_type       cfg_ff;
   ptid_pkg::cfg_type       cfg_in;
   ptid_pkg::reg_index_type index;
   logic                    write_en;

   assign index    = ptid_pkg::reg_index_type'(paddr[4:2]);
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            ptid_pkg::REG_PALETTE_0:  cfg_in.palette[0] = pwdata;
            ptid_pkg::REG_PALETTE_1:  cfg_in.palette[1] = pwdata;
            ptid_pkg::REG_PALETTE_2:  cfg_in.palette[2] = pwdata;
            ptid_pkg::REG_PALETTE_3:  cfg_in.palette[3] = pwdata;
            ptid_pkg::REG_TALL_TILES: cfg_in.tall_tiles = pwdata[0];
            ptid_pkg::REG_GRID_WIDTH: cfg_in.grid_width_tiles = pwdata[6:0];
            ptid_pkg::REG_TILE_TOTAL: cfg_in.tile_total = pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         ptid_pkg::REG_PALETTE_0:  prdata = cfg_ff.palette[0];
         ptid_pkg::REG_PALETTE_1:  prdata = cfg_ff.palette[1];
         ptid_pkg::REG_PALETTE_2:  prdata = cfg_ff.palette[2];
         ptid_pkg::REG_PALETTE_3:  prdata = cfg_ff.palette[3];
         ptid_pkg::REG_TALL_TILES: prdata = {31'd0, cfg_ff.tall_tiles};
         ptid_pkg::REG_GRID_WIDTH: prdata = {25'd0, cfg_ff.grid_width_tiles};
         ptid_pkg::REG_TILE_TOTAL: prdata = {21'd0, cfg_ff.tile_total};
         default:                  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.palette[0]       <= ptid_pkg::PALETTE_0_RESET;
         cfg_ff.palette[1]       <= ptid_pkg::PALETTE_1_RESET;
         cfg_ff.palette[2]       <= ptid_pkg::PALETTE_2_RESET;
         cfg_ff.palette[3]       <= ptid_pkg::PALETTE_3_RESET;
         cfg_ff.tall_tiles       <= 1'b0;
         cfg_ff.grid_width_tiles <= ptid_pkg::GRID_WIDTH_RESET;
         cfg_ff.tile_total       <= ptid_pkg::TILE_TOTAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/ptid_line.sv @@
// ----------------------------------------------------------------------------
// ptid_line
// Tile line decode: palette lookup per pixel, grid position counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptid_line (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ptid_pkg::cfg_type cfg,
   input  wire logic              advance,
   input  wire ptid_pkg::req_type line_data,
   output ptid_pkg::rsp_type      result
);

   logic [3:0]  line_ff,  line_in;
   logic [5:0]  col_ff,   col_in;
   logic [9:0]  row_ff,   row_in;
   logic [10:0] tiles_ff, tiles_in;

   logic [7:0][31:0] pixels;
   logic [13:0]      row_base;
   logic [10:0]      eff_total;
   logic [6:0]       eff_width;
   logic [11:0]      tiles_next;
   logic [6:0]       col_next;
   logic             last_line;
   logic             done;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         pixels[i] = cfg.palette[{line_data.plane_high[7-i], line_data.plane_low[7-i]}];
      end
   end

   always_comb begin
      eff_total = cfg.tile_total;
      if (eff_total == 11'd0) begin
         eff_total = 11'd1;
      end
      if (eff_total > ptid_pkg::TILE_LIMIT) begin
         eff_total = ptid_pkg::TILE_LIMIT;
      end
      eff_width = cfg.grid_width_tiles;
      if (eff_width == 7'd0) begin
         eff_width = 7'd1;
      end
      if (eff_width > ptid_pkg::GRID_LIMIT) begin
         eff_width = ptid_pkg::GRID_LIMIT;
      end
   end

   assign row_base   = cfg.tall_tiles ? {row_ff, 4'd0} : {1'b0, row_ff, 3'd0};
   assign last_line  = cfg.tall_tiles ? (line_ff == 4'd15) : (line_ff >= 4'd7);
   assign tiles_next = {1'b0, tiles_ff} + 12'd1;
   assign col_next   = {1'b0, col_ff} + 7'd1;
   assign done       = last_line && (tiles_next >= {1'b0, eff_total});

   always_comb begin
      result.pixel_0     = pixels[0];
      result.pixel_1     = pixels[1];
      result.pixel_2     = pixels[2];
      result.pixel_3     = pixels[3];
      result.pixel_4     = pixels[4];
      result.pixel_5     = pixels[5];
      result.pixel_6     = pixels[6];
      result.pixel_7     = pixels[7];
      result.dest_row    = row_base + {10'd0, line_ff};
      result.dest_column = {col_ff, 3'd0};
      result.image_done  = done;
   end

   always_comb begin
      line_in  = line_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      tiles_in = tiles_ff;
      priority if (done) begin
         line_in  = '0;
         col_in   = '0;
         row_in   = '0;
         tiles_in = '0;
      end else if (last_line) begin
         line_in  = '0;
         tiles_in = tiles_next[10:0];
         if (col_next >= eff_width) begin
            col_in = '0;
            row_in = row_ff + 10'd1;
         end else begin
            col_in = col_next[5:0];
         end
      end else begin
         line_in = line_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff  <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         tiles_ff <= '0;
      end else if (advance) begin
         line_ff  <= line_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         tiles_ff <= tiles_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/ptid_checker.sv @@
// ----------------------------------------------------------------------------
// ptid_checker
// Port-level checks of the tile decoder's flow control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "planar_tile_image_decoder_macros.svh"

module ptid_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire ptid_pkg::rsp_type rsp_data
);

   `PTID_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "stalled transaction changed")
   `PTID_ASSERT_SAME(a_stall_needs_rsp, clock, reset, req_stall, rsp_valid,
      "input stalled with no result pending")
   `PTID_ASSERT_NEXT(a_accept_to_rsp, clock, reset, req_valid && !req_stall && !rsp_valid,
      rsp_valid, "accepted transaction produced no result")
   `PTID_ASSERT_SAME(a_rsp_from_req, clock, reset, $rose(rsp_valid),
      $past(req_valid && !req_stall), "result without accepted transaction")

endmodule

bind planar_tile_image_decoder ptid_checker u_ptid_checker (.*);

`default_nettype wire
